### hw/rtl/ofx_pkg.sv
// ----------------------------------------------------------------------------
// Orbit frame transform package
// Shared constants and a latency helper for the orbital frame transform.
// ----------------------------------------------------------------------------
package ofx_pkg;

  localparam int COORD_WIDTH    = 32;
  localparam int UNIT_FRAC_BITS = 30;

  // Mantissa width after normalization; the squared sum fits 64 bits.
  localparam int MANT_BITS   = 31;
  localparam int SUM_BITS    = 2 * MANT_BITS + 2;
  localparam int ROOT_BITS   = SUM_BITS / 2;
  localparam int SQRT_STAGES = SUM_BITS / 2;

  // Absolute value, bit length, shift, square, sum.
  localparam int NORM_STAGES = 5;

  localparam int QUEUE_DEPTH = 4;

  // Cycles from the first unit-vector stage to the registered unit vector.
  function automatic int unit_latency(input int frac_bits);
    return NORM_STAGES + SQRT_STAGES + frac_bits + 1 + 1;
  endfunction

endpackage

### hw/rtl/ofx_queue.sv
// ----------------------------------------------------------------------------
// Orbit frame transform queue
// Small FIFO that decouples the front stages from the back pipeline.
// ----------------------------------------------------------------------------
module ofx_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ofx_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    count_r;
  logic             do_pop;

  assign do_pop    = pop && (count_r != '0);
  assign not_empty = (count_r != '0);
  assign count     = count_r;
  assign pop_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH-1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH-1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!push && do_pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/ofx_front.sv
// ----------------------------------------------------------------------------
// Orbit frame transform front end
// Accepts items, forms the offset and the orbit normal, flags degenerate cases.
// ----------------------------------------------------------------------------
module ofx_front #(
  parameter int COORD_WIDTH = ofx_pkg::COORD_WIDTH,
  parameter int QD          = ofx_pkg::QUEUE_DEPTH,
  localparam int W          = COORD_WIDTH,
  localparam int IW         = 1 + 3 * (W + 1) + 3 * (2 * W + 1) + 6 * W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [W-1:0]     point [3],
  input  logic signed [W-1:0]     pos [3],
  input  logic signed [W-1:0]     vel [3],
  input  logic [$clog2(QD+1)-1:0] q_count,
  output logic                    push,
  output logic [IW-1:0]           push_data
);

  localparam int R_LO   = 0;
  localparam int V_LO   = 3 * W;
  localparam int H_LO   = 6 * W;
  localparam int D_LO   = H_LO + 3 * (2 * W + 1);
  localparam int DEG_AT = D_LO + 3 * (W + 1);
  localparam int SW     = $clog2(QD+1) + 1;

  logic                  accept;
  logic                  s1_valid_r, s2_valid_r;
  logic signed [W-1:0]   r1_r [3], v1_r [3];
  logic signed [W:0]     d1_r [3];
  logic signed [2*W-1:0] pa_r [3], pb_r [3];
  logic signed [W-1:0]   r2_r [3], v2_r [3];
  logic signed [W:0]     d2_r [3];
  logic signed [2*W:0]   h2_r [3];
  logic                  deg2_r;
  logic [SW-1:0]         pending;

  // Hold off when the queue could not take every item still in the front.
  assign pending = SW'(q_count) + SW'(s1_valid_r) + SW'(s2_valid_r);
  assign busy    = (pending >= SW'(QD));
  assign accept  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        r1_r[i] <= pos[i];
        v1_r[i] <= vel[i];
        d1_r[i] <= (W+1)'(point[i]) - (W+1)'(pos[i]);
      end
      pa_r[0] <= pos[1] * vel[2];
      pb_r[0] <= pos[2] * vel[1];
      pa_r[1] <= pos[2] * vel[0];
      pb_r[1] <= pos[0] * vel[2];
      pa_r[2] <= pos[0] * vel[1];
      pb_r[2] <= pos[1] * vel[0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        r2_r[i] <= r1_r[i];
        v2_r[i] <= v1_r[i];
        d2_r[i] <= d1_r[i];
        h2_r[i] <= (2*W+1)'(pa_r[i]) - (2*W+1)'(pb_r[i]);
      end
      deg2_r <= ((r1_r[0] == '0) && (r1_r[1] == '0) && (r1_r[2] == '0)) ||
                ((v1_r[0] == '0) && (v1_r[1] == '0) && (v1_r[2] == '0)) ||
                ((pa_r[0] == pb_r[0]) && (pa_r[1] == pb_r[1]) && (pa_r[2] == pb_r[2]));
    end
  end

  assign push = s2_valid_r;

  for (genvar i = 0; i < 3; i++) begin : g_pack
    assign push_data[R_LO + i*W +: W]             = r2_r[i];
    assign push_data[V_LO + i*W +: W]             = v2_r[i];
    assign push_data[H_LO + i*(2*W+1) +: 2*W+1]   = h2_r[i];
    assign push_data[D_LO + i*(W+1) +: W+1]       = d2_r[i];
  end
  assign push_data[DEG_AT] = deg2_r;

endmodule

### hw/rtl/ofx_isqrt.sv
// ----------------------------------------------------------------------------
// Orbit frame transform square root
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ofx_isqrt (
  input  logic                           clk,
  input  logic [ofx_pkg::SUM_BITS-1:0]   x_in,
  output logic [ofx_pkg::ROOT_BITS-1:0]  root
);

  localparam int SB = ofx_pkg::SUM_BITS;
  localparam int NS = ofx_pkg::SQRT_STAGES;

  logic [SB-1:0] rem_r [NS];
  logic [SB-1:0] res_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [SB-1:0] BITV = SB'(1) << (SB - 2 - 2 * k);
    logic [SB-1:0] rem_in, res_in, trial;

    if (k == 0) begin : g_first
      assign rem_in = x_in;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign res_in = res_r[k-1];
    end

    assign trial = res_in + BITV;

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[k] <= rem_in - trial;
        res_r[k] <= (res_in >> 1) + BITV;
      end else begin
        rem_r[k] <= rem_in;
        res_r[k] <= res_in >> 1;
      end
    end
  end

  assign root = res_r[NS-1][ofx_pkg::ROOT_BITS-1:0];

endmodule

### hw/rtl/ofx_div.sv
// ----------------------------------------------------------------------------
// Orbit frame transform divider
// Pipelined restoring division of a rounded, scaled mantissa by the norm.
// ----------------------------------------------------------------------------
module ofx_div #(
  parameter int UNIT_FRAC_BITS = ofx_pkg::UNIT_FRAC_BITS,
  localparam int QB            = UNIT_FRAC_BITS + 1,
  localparam int MB            = ofx_pkg::MANT_BITS
) (
  input  logic          clk,
  input  logic [MB:0]   n_in,
  input  logic [MB-1:0] m_in,
  output logic [QB-1:0] q_out
);

  localparam int F  = UNIT_FRAC_BITS;
  localparam int NW = MB + QB;

  logic [NW-1:0] num;
  logic [MB:0]   rem_r [QB];
  logic [QB-1:0] lo_r [QB];
  logic [QB-1:0] q_r [QB];
  logic [MB:0]   n_r [QB];

  // The quotient never exceeds 2^F, so only QB quotient bits are formed.
  assign num = NW'({m_in, {F{1'b0}}}) + NW'(n_in >> 1);

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic [MB:0]   rem_in, nn, rem_nxt;
    logic [QB-1:0] lo_in, q_in;
    logic [MB+1:0] t;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in = (MB+1)'(num[NW-1:QB]);
      assign lo_in  = num[QB-1:0];
      assign q_in   = '0;
      assign nn     = n_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign lo_in  = lo_r[j-1];
      assign q_in   = q_r[j-1];
      assign nn     = n_r[j-1];
    end

    assign t       = {rem_in, lo_in[QB-1]};
    assign ge      = (t >= {1'b0, nn});
    assign rem_nxt = ge ? (MB+1)'(t - {1'b0, nn}) : t[MB:0];

    always_ff @(posedge clk) begin
      rem_r[j] <= rem_nxt;
      lo_r[j]  <= lo_in << 1;
      q_r[j]   <= {q_in[QB-2:0], ge};
      n_r[j]   <= nn;
    end
  end

  assign q_out = q_r[QB-1];

endmodule

### hw/rtl/ofx_unit.sv
// ----------------------------------------------------------------------------
// Orbit frame transform unit vector
// Normalizes a signed 3-vector, takes its norm and divides to a signed unit.
// ----------------------------------------------------------------------------
module ofx_unit #(
  parameter int CW             = ofx_pkg::COORD_WIDTH,
  parameter int UNIT_FRAC_BITS = ofx_pkg::UNIT_FRAC_BITS,
  localparam int EW            = UNIT_FRAC_BITS + 2
) (
  input  logic                 clk,
  input  logic signed [CW-1:0] c [3],
  output logic signed [EW-1:0] e [3]
);

  localparam int MB = ofx_pkg::MANT_BITS;
  localparam int SB = ofx_pkg::SUM_BITS;
  localparam int QB = UNIT_FRAC_BITS + 1;
  localparam int LW = $clog2(CW + 1);
  localparam int ML = ofx_pkg::SQRT_STAGES + 2;
  localparam int NL = ML + QB;

  function automatic logic [LW-1:0] bit_len(input logic [CW-1:0] x);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (x[i]) begin
        n = LW'(i + 1);
      end
    end
    return n;
  endfunction

  logic [CW-1:0]          a1_r [3], a2_r [3];
  logic                   neg1_r [3], neg2_r [3], neg3_r [3];
  logic [LW-1:0]          len_r;
  logic [MB-1:0]          m_r [3];
  logic [2*MB-1:0]        sq_r [3];
  logic [SB-1:0]          sum_r;
  logic [MB-1:0]          md_r [3][ML];
  logic                   nd_r [3][NL];
  logic [MB:0]            root;
  logic [QB-1:0]          q [3];
  logic [CW+MB-1:0]       shifted [3];

  ofx_isqrt u_sqrt (
    .clk  (clk),
    .x_in (sum_r),
    .root (root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    // Scale by 2^MB, then shift back by the bit length: this covers both
    // the left and the truncating right normalization.
    assign shifted[i] = {a2_r[i], {MB{1'b0}}} >> len_r;

    always_ff @(posedge clk) begin
      a1_r[i]   <= c[i][CW-1] ? (~c[i] + CW'(1)) : c[i];
      neg1_r[i] <= c[i][CW-1];
      a2_r[i]   <= a1_r[i];
      neg2_r[i] <= neg1_r[i];
      m_r[i]    <= shifted[i][MB-1:0];
      neg3_r[i] <= neg2_r[i];
      sq_r[i]   <= m_r[i] * m_r[i];
      md_r[i][0] <= m_r[i];
      nd_r[i][0] <= neg3_r[i];
      for (int j = 1; j < ML; j++) begin
        md_r[i][j] <= md_r[i][j-1];
      end
      for (int j = 1; j < NL; j++) begin
        nd_r[i][j] <= nd_r[i][j-1];
      end
      e[i] <= nd_r[i][NL-1] ? -$signed(EW'(q[i])) : $signed(EW'(q[i]));
    end

    ofx_div #(
      .UNIT_FRAC_BITS (UNIT_FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .n_in  (root),
      .m_in  (md_r[i][ML-1]),
      .q_out (q[i])
    );
  end

  always_ff @(posedge clk) begin
    len_r <= bit_len(a1_r[0] | a1_r[1] | a1_r[2]);
    sum_r <= SB'(sq_r[0]) + SB'(sq_r[1]) + SB'(sq_r[2]);
  end

endmodule

### hw/rtl/ofx_back.sv
// ----------------------------------------------------------------------------
// Orbit frame transform back end
// Builds the three unit vectors, rotates the offset, rounds and saturates.
// ----------------------------------------------------------------------------
module ofx_back #(
  parameter int COORD_WIDTH    = ofx_pkg::COORD_WIDTH,
  parameter int UNIT_FRAC_BITS = ofx_pkg::UNIT_FRAC_BITS,
  localparam int W             = COORD_WIDTH,
  localparam int IW            = 1 + 3 * (W + 1) + 3 * (2 * W + 1) + 6 * W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  logic [IW-1:0]       item,
  output logic                out_valid,
  output logic signed [W-1:0] out_along,
  output logic signed [W-1:0] out_normal,
  output logic signed [W-1:0] out_nadir,
  output logic                out_degenerate
);

  localparam int F      = UNIT_FRAC_BITS;
  localparam int EW     = F + 2;
  localparam int HW     = 2 * W + 1;
  localparam int R_LO   = 0;
  localparam int V_LO   = 3 * W;
  localparam int H_LO   = 6 * W;
  localparam int D_LO   = H_LO + 3 * HW;
  localparam int DEG_AT = D_LO + 3 * (W + 1);
  localparam int UL     = ofx_pkg::unit_latency(F);
  localparam int VL     = UL + 3;
  localparam int PW     = EW + W + 1;
  localparam int AW     = PW + 2;
  localparam int RW     = AW - F;

  logic signed [W-1:0]  rv [3], vv [3];
  logic signed [HW-1:0] hv [3];
  logic signed [EW-1:0] e0 [3], e1 [3], e2raw [3], ek [3][3];
  logic signed [W:0]    dd_r [3][UL];
  logic                 vd_r [VL];
  logic                 gd_r [VL];
  logic signed [PW-1:0] prod_r [3][3];
  logic signed [AW-1:0] acc_r [3];
  logic [AW-1:0]        mag [3];
  logic [RW-1:0]        rnd_r [3];
  logic                 neg_r [3];
  logic [W-1:0]         sat [3];
  logic [RW-1:0]        lim;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign rv[i]    = item[R_LO + i*W +: W];
    assign vv[i]    = item[V_LO + i*W +: W];
    assign hv[i]    = item[H_LO + i*HW +: HW];
    assign ek[0][i] = e0[i];
    assign ek[1][i] = e1[i];
    assign ek[2][i] = -e2raw[i];
  end

  ofx_unit #(.CW(W), .UNIT_FRAC_BITS(F)) u_along (
    .clk (clk), .c (vv), .e (e0)
  );
  ofx_unit #(.CW(HW), .UNIT_FRAC_BITS(F)) u_normal (
    .clk (clk), .c (hv), .e (e1)
  );
  ofx_unit #(.CW(W), .UNIT_FRAC_BITS(F)) u_nadir (
    .clk (clk), .c (rv), .e (e2raw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < VL; j++) begin
        vd_r[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      vd_r[0] <= item_valid;
      for (int j = 1; j < VL; j++) begin
        vd_r[j] <= vd_r[j-1];
      end
      out_valid <= vd_r[VL-1];
    end
  end

  assign lim = RW'(1) << (W - 1);

  for (genvar k = 0; k < 3; k++) begin : g_row
    assign mag[k] = acc_r[k][AW-1] ? AW'(-acc_r[k]) : AW'(acc_r[k]);

    always_comb begin
      if (neg_r[k]) begin
        sat[k] = (rnd_r[k] > lim) ? W'(-lim) : W'(-rnd_r[k]);
      end else begin
        sat[k] = (rnd_r[k] > lim - RW'(1)) ? W'(lim - RW'(1)) : W'(rnd_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    gd_r[0] <= item[DEG_AT];
    for (int j = 1; j < VL; j++) begin
      gd_r[j] <= gd_r[j-1];
    end
    for (int i = 0; i < 3; i++) begin
      dd_r[i][0] <= item[D_LO + i*(W+1) +: W+1];
      for (int j = 1; j < UL; j++) begin
        dd_r[i][j] <= dd_r[i][j-1];
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[k][i] <= ek[k][i] * dd_r[i][UL-1];
      end
      acc_r[k] <= AW'(prod_r[k][0]) + AW'(prod_r[k][1]) + AW'(prod_r[k][2]);
      // Round the magnitude half away from zero, then restore the sign.
      rnd_r[k] <= RW'((mag[k] + (AW'(1) << (F - 1))) >> F);
      neg_r[k] <= acc_r[k][AW-1];
    end
    out_degenerate <= gd_r[VL-1];
    out_along      <= gd_r[VL-1] ? '0 : sat[0];
    out_normal     <= gd_r[VL-1] ? '0 : sat[1];
    out_nadir      <= gd_r[VL-1] ? '0 : sat[2];
  end

endmodule

### hw/rtl/orbit_frame_transform_unit.sv
// A transfer passes the front stages, the queue, the unit-vector pipelines
// (square root and divider, one result bit per stage) and the rotate, round
// and saturate registers before the strobe.
// Throughput: one item per cycle; busy never rises, since the back end takes
// a queued item every cycle.
// Reset clears the handshake and pipeline valid bits; results cannot stall.
// ----------------------------------------------------------------------------
// Orbit frame transform unit
// Expresses a point in the along-track / orbit-normal / nadir frame.
// ----------------------------------------------------------------------------
module orbit_frame_transform_unit #(
  parameter int COORD_WIDTH    = ofx_pkg::COORD_WIDTH,
  parameter int UNIT_FRAC_BITS = ofx_pkg::UNIT_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_vel_y,
  input  logic signed [COORD_WIDTH-1:0] in_vel_z,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_along,
  output logic signed [COORD_WIDTH-1:0] out_normal,
  output logic signed [COORD_WIDTH-1:0] out_nadir,
  output logic                          out_degenerate
);

  localparam int W  = COORD_WIDTH;
  localparam int QD = ofx_pkg::QUEUE_DEPTH;
  localparam int IW = 1 + 3 * (W + 1) + 3 * (2 * W + 1) + 6 * W;

  logic signed [W-1:0]      point [3], pos [3], vel [3];
  logic                     push, q_not_empty;
  logic [IW-1:0]            push_data, pop_data;
  logic [$clog2(QD+1)-1:0]  q_count;

  assign point = '{in_point_x, in_point_y, in_point_z};
  assign pos   = '{in_pos_x, in_pos_y, in_pos_z};
  assign vel   = '{in_vel_x, in_vel_y, in_vel_z};

  ofx_front #(.COORD_WIDTH(W), .QD(QD)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .pos       (pos),
    .vel       (vel),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  ofx_queue #(.WIDTH(IW), .DEPTH(QD)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_not_empty),
    .pop_data  (pop_data),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  ofx_back #(.COORD_WIDTH(W), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (q_not_empty),
    .item           (pop_data),
    .out_valid      (out_valid),
    .out_along      (out_along),
    .out_normal     (out_normal),
    .out_nadir      (out_nadir),
    .out_degenerate (out_degenerate)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Orbit frame transform unit testbench
// Drives point, position and velocity triples, predicts the orbital frame
// coordinates with a bit-accurate software model and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import ofx_pkg::*;

  localparam int W        = COORD_WIDTH;
  localparam int F        = UNIT_FRAC_BITS;
  localparam int LATENCY  = unit_latency(UNIT_FRAC_BITS) + 7;
  localparam int WD_LIMIT = 40 * LATENCY + 2000;

  typedef logic signed [W-1:0] coord_t;

  typedef struct {
    coord_t along;
    coord_t normal;
    coord_t nadir;
    logic   degen;
  } frame_coord_t;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_point_x, in_point_y, in_point_z;
  coord_t in_pos_x, in_pos_y, in_pos_z;
  coord_t in_vel_x, in_vel_y, in_vel_z;
  logic   out_valid;
  coord_t out_along, out_normal, out_nadir;
  logic   out_degenerate;

  frame_coord_t expected_coords[$];
  int           error_count;
  int           idle_cycles;

  orbit_frame_transform_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_pos_z       (in_pos_z),
    .in_vel_x       (in_vel_x),
    .in_vel_y       (in_vel_y),
    .in_vel_z       (in_vel_z),
    .out_valid      (out_valid),
    .out_along      (out_along),
    .out_normal     (out_normal),
    .out_nadir      (out_nadir),
    .out_degenerate (out_degenerate)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int bit_len(logic [127:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (x[i]) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] b;
    root = 0;
    rem = x;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Normalizes a nonzero vector to a 31-bit mantissa and divides by the
  // integer root of the squared sum to get a Q2.F unit vector.
  task automatic unit_vector(input logic signed [127:0] c[3],
                             output logic signed [127:0] u[3]);
    logic [127:0] mag[3];
    logic [63:0]  mant[3];
    logic [63:0]  sum;
    logic [63:0]  root;
    logic [127:0] num;
    logic [127:0] q;
    int           len;
    len = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      if (bit_len(mag[i]) > len) len = bit_len(mag[i]);
    end
    for (int i = 0; i < 3; i++) begin
      mant[i] = len > 31 ? mag[i] >> (len - 31) : mag[i] << (31 - len);
      sum = sum + mant[i] * mant[i];
    end
    root = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      num = ({64'd0, mant[i]} << F) + (root >> 1);
      q = num / root;
      u[i] = c[i] < 0 ? -$signed(q) : $signed(q);
    end
  endtask

  task automatic predict_frame(input coord_t p[3], input coord_t r[3], input coord_t v[3],
                               output frame_coord_t res);
    logic signed [127:0] rv[3], vv[3], hv[3], d[3];
    logic signed [127:0] e[3][3];
    logic signed [127:0] u[3];
    logic signed [127:0] acc;
    logic [127:0]        mag;
    logic [127:0]        lim;
    coord_t              val[3];
    for (int i = 0; i < 3; i++) begin
      rv[i] = r[i];
      vv[i] = v[i];
      d[i] = 128'(signed'(p[i])) - 128'(signed'(r[i]));
    end
    hv[0] = rv[1] * vv[2] - rv[2] * vv[1];
    hv[1] = rv[2] * vv[0] - rv[0] * vv[2];
    hv[2] = rv[0] * vv[1] - rv[1] * vv[0];
    res.degen = 1'b0;
    if ((rv[0] == 0 && rv[1] == 0 && rv[2] == 0) || (vv[0] == 0 && vv[1] == 0 && vv[2] == 0)
        || (hv[0] == 0 && hv[1] == 0 && hv[2] == 0)) begin
      res = '{along: '0, normal: '0, nadir: '0, degen: 1'b1};
      return;
    end
    unit_vector(vv, u);
    e[0] = u;
    unit_vector(hv, u);
    e[1] = u;
    unit_vector(rv, u);
    for (int i = 0; i < 3; i++) e[2][i] = -u[i];
    lim = 128'd1 << (W - 1);
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) acc = acc + e[k][i] * d[i];
      mag = acc < 0 ? -acc : acc;
      mag = (mag + (128'd1 << (F - 1))) >> F;
      if (acc < 0) begin
        if (mag > lim) mag = lim;
        val[k] = coord_t'(-mag);
      end else begin
        if (mag > lim - 1) mag = lim - 1;
        val[k] = coord_t'(mag);
      end
    end
    res.along = val[0];
    res.normal = val[1];
    res.nadir = val[2];
  endtask

  // Start stays high into the next call, so a zero gap gives back-to-back
  // transfers; a nonzero gap drops it between transfers.
  task automatic send_triple(input coord_t p[3], input coord_t r[3], input coord_t v[3]);
    frame_coord_t res;
    int           gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {in_point_x, in_point_y, in_point_z} <= {p[0], p[1], p[2]};
    {in_pos_x, in_pos_y, in_pos_z} <= {r[0], r[1], r[2]};
    {in_vel_x, in_vel_y, in_vel_z} <= {v[0], v[1], v[2]};
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_frame(p, r, v, res);
    expected_coords.push_back(res);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 40)) - 20;
      1: return $urandom_range(0, 1) ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
      2: return coord_t'(signed'($urandom_range(0, 2000000))) - 1000000;
      default: return coord_t'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin
    frame_coord_t exp_c;
    if (rst_n && out_valid) begin
      if (expected_coords.size() == 0) begin
        $display("%0t: result with no transfer pending: %0d %0d %0d %b", $time,
                 out_along, out_normal, out_nadir, out_degenerate);
        error_count++;
      end else begin
        exp_c = expected_coords.pop_front();
        if (out_along !== exp_c.along || out_normal !== exp_c.normal ||
            out_nadir !== exp_c.nadir || out_degenerate !== exp_c.degen) begin
          $display("%0t: expected %0d %0d %0d %b, actual %0d %0d %0d %b", $time,
                   exp_c.along, exp_c.normal, exp_c.nadir, exp_c.degen,
                   out_along, out_normal, out_nadir, out_degenerate);
          error_count++;
        end
      end
    end
  end

  // Counts cycles without any transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("[orbit_frame_transform_unit] ERROR");
        $finish;
      end
    end
  end

  task automatic test_extremes();
    coord_t mx, mn, p[3], r[3], v[3];
    mx = {1'b0, {(W - 1){1'b1}}};
    mn = {1'b1, {(W - 1){1'b0}}};
    // Zero position, zero velocity, parallel vectors.
    p = '{5, 6, 7}; r = '{0, 0, 0}; v = '{1, 2, 3};
    send_triple(p, r, v);
    r = '{1, 2, 3}; v = '{0, 0, 0};
    send_triple(p, r, v);
    v = '{-2, -4, -6};
    send_triple(p, r, v);
    r = '{mx, mx, mx}; v = '{mn, mn, mn};
    send_triple(p, r, v);
    // Basic orbit and saturating extremes.
    r = '{1000, 0, 0}; v = '{0, 7, 0}; p = '{1000, 0, 0};
    send_triple(p, r, v);
    p = '{0, 0, 0};
    send_triple(p, r, v);
    r = '{mn, mn, mx}; v = '{mx, mn, mn}; p = '{mx, mx, mn};
    send_triple(p, r, v);
    r = '{mx, 0, 0}; v = '{0, mx, 0}; p = '{mn, mn, mn};
    send_triple(p, r, v);
    r = '{mn, 0, 0}; v = '{0, 0, mn}; p = '{mx, mx, mx};
    send_triple(p, r, v);
    r = '{1, 0, 0}; v = '{0, 1, 0}; p = '{mn, mx, mn};
    send_triple(p, r, v);
    r = '{-1, -1, -1}; v = '{1, -1, 0}; p = '{-1, 2, -3};
    send_triple(p, r, v);
    r = '{3, 4, 0}; v = '{-4, 3, 0}; p = '{mx, mn, mx};
    send_triple(p, r, v);
  endtask

  task automatic test_random();
    coord_t p[3], r[3], v[3];
    for (int n = 0; n < 1150; n++) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = rand_coord();
        r[i] = rand_coord();
        v[i] = rand_coord();
      end
      // Some parallel velocities and zero vectors keep the degenerate path busy.
      case ($urandom_range(0, 19))
        0: v = '{r[0] * 2, r[1] * 2, r[2] * 2};
        1: r = '{0, 0, 0};
        2: v = '{0, 0, 0};
        default: ;
      endcase
      send_triple(p, r, v);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_point_x, in_point_y, in_point_z} = '0;
    {in_pos_x, in_pos_y, in_pos_z} = '0;
    {in_vel_x, in_vel_y, in_vel_z} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_random();
    drain_results();
    if (error_count == 0) begin
      $display("[orbit_frame_transform_unit] OK");
    end else begin
      $display("[orbit_frame_transform_unit] ERROR");
    end
    $finish;
  end

endmodule
